[rtl/core/utf8d_pkg.sv]
package utf8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpW-1:0] MinTwo      = 21'h000080;
  localparam logic [CpW-1:0] MinThree    = 21'h000800;
  localparam logic [CpW-1:0] MinFour     = 21'h010000;
  localparam logic [CpW-1:0] SurrLo      = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi      = 21'h00DFFF;
  localparam logic [CpW-1:0] MaxScalar   = 21'h10FFFF;

  // Sequence length codes
  localparam logic [2:0] LenNone  = 3'd0;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  // One run of results caused by one input word: replacements before the
  // main result, the main result itself (optional), replacements after it.
  typedef struct packed {
    logic [2:0]     count;
    logic           has_main;
    logic [1:0]     main_idx;
    logic [CpW-1:0] main_cp;
    logic           main_rep;
    logic           eot;
  } run_t;

endpackage

[rtl/core/utf8d_if.sv]
interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface utf8d_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        replaced;
  logic        run_last;
  logic        text_last;

  modport source (output valid, output code_point, output replaced, output run_last,
                  output text_last, input ready);
  modport sink   (input valid, input code_point, input replaced, input run_last,
                  input text_last, output ready);
endinterface

[rtl/core/utf8_stream_decoder_core.sv]
// The first code point of a byte passes through the run queue and then the output register.
// Throughput: one byte per cycle while each byte gives at most one code point and the
// output does not stall; a byte that gives n code points (n up to 4) sends them out one
// by one, the run queue absorbing the difference until it fills and the input stalls.
// Reset: asynchronous, active low; clears sequence state, queue and output valid.
module utf8_stream_decoder_core
  import utf8d_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  utf8d_byte_if.sink     byte_i,
  utf8d_cp_if.source     cp_o
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  run_t run_in;
  run_t run_out;

  // Accept and classify words
  utf8d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (byte_i.valid),
    .data_byte_i   (byte_i.data_byte),
    .end_of_text_i (byte_i.end_of_text),
    .in_ready_o    (byte_i.ready),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_run_o       (run_in)
  );

  // Buffer runs between the two sides
  utf8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .run_i   (run_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .run_o   (run_out)
  );

  // Expand runs into output words
  utf8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_run_i      (run_out),
    .q_pop_o      (q_pop),
    .out_valid_o  (cp_o.valid),
    .out_ready_i  (cp_o.ready),
    .code_point_o (cp_o.code_point),
    .replaced_o   (cp_o.replaced),
    .run_last_o   (cp_o.run_last),
    .text_last_o  (cp_o.text_last)
  );

endmodule

[rtl/core/utf8d_front.sv]
module utf8d_front
  import utf8d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_text_i,
  output logic       in_ready_o,
  input  logic       q_full_i,
  output logic       q_push_o,
  output run_t       q_run_o
);

  logic [7:0]  held_q [3];
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic [2:0]  exp_len_q, exp_len_d;

  logic        accept;
  logic        open_seq;
  logic        is_cont;
  logic        is_ascii;
  logic [2:0]  lead_len;
  logic [1:0]  pre_cnt;
  logic [1:0]  post_cnt;
  logic        has_main;
  logic [CpW-1:0] main_cp;
  logic        main_rep;
  logic        wr_held;
  logic [1:0]  wr_idx;
  logic [CpW-1:0] seq_val;
  logic        seq_ok;
  logic        seq_done;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign open_seq   = held_cnt_q != 2'd0;
  assign is_cont    = data_byte_i[7:6] == 2'b10;
  assign is_ascii   = !data_byte_i[7];
  assign seq_done   = ({1'b0, held_cnt_q} + 3'd1) >= exp_len_q;

  // Classify a lead word
  always_comb begin
    if (data_byte_i[7:5] == 3'b110) begin
      lead_len = LenTwo;
    end else if (data_byte_i[7:4] == 4'b1110) begin
      lead_len = LenThree;
    end else if (data_byte_i[7:3] == 5'b11110) begin
      lead_len = LenFour;
    end else begin
      lead_len = LenNone;
    end
  end

  // Assemble and check a completed sequence
  always_comb begin
    unique case (exp_len_q)
      LenTwo:   seq_val = {10'd0, held_q[0][4:0], data_byte_i[5:0]};
      LenThree: seq_val = {5'd0, held_q[0][3:0], held_q[1][5:0], data_byte_i[5:0]};
      default:  seq_val = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0],
                           data_byte_i[5:0]};
    endcase
    unique case (exp_len_q)
      LenTwo:   seq_ok = seq_val >= MinTwo;
      LenThree: seq_ok = (seq_val >= MinThree) && ((seq_val < SurrLo) || (seq_val > SurrHi));
      default:  seq_ok = (seq_val >= MinFour) && (seq_val <= MaxScalar);
    endcase
  end

  // Decode one word into a run and the next sequence state
  always_comb begin
    held_cnt_d = held_cnt_q;
    exp_len_d  = exp_len_q;
    pre_cnt    = 2'd0;
    has_main   = 1'b0;
    main_cp    = Replacement;
    main_rep   = 1'b1;
    wr_held    = 1'b0;
    wr_idx     = held_cnt_q;

    if (open_seq && is_cont) begin
      if (seq_done) begin
        has_main   = 1'b1;
        main_cp    = seq_ok ? seq_val : Replacement;
        main_rep   = !seq_ok;
        held_cnt_d = 2'd0;
        exp_len_d  = LenNone;
      end else begin
        wr_held    = 1'b1;
        held_cnt_d = held_cnt_q + 2'd1;
      end
    end else begin
      // drop a broken sequence, then handle the word as a fresh one
      pre_cnt    = open_seq ? held_cnt_q : 2'd0;
      held_cnt_d = 2'd0;
      exp_len_d  = LenNone;
      if (is_ascii) begin
        has_main = 1'b1;
        main_cp  = {13'd0, data_byte_i};
        main_rep = 1'b0;
      end else if (lead_len != LenNone) begin
        wr_held    = 1'b1;
        wr_idx     = 2'd0;
        held_cnt_d = 2'd1;
        exp_len_d  = lead_len;
      end else begin
        has_main = 1'b1;
      end
    end

    // flush whatever is still open at end of text
    post_cnt = end_of_text_i ? held_cnt_d : 2'd0;
    if (end_of_text_i) begin
      held_cnt_d = 2'd0;
      exp_len_d  = LenNone;
    end

    q_run_o.count    = {1'b0, pre_cnt} + {2'b0, has_main} + {1'b0, post_cnt};
    q_run_o.has_main = has_main;
    q_run_o.main_idx = pre_cnt;
    q_run_o.main_cp  = main_cp;
    q_run_o.main_rep = main_rep;
    q_run_o.eot      = end_of_text_i;
  end

  assign q_push_o = accept && (q_run_o.count != 3'd0);

  // Advance sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      exp_len_q  <= LenNone;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
      exp_len_q  <= exp_len_d;
    end
  end

  // Hold sequence words
  always_ff @(posedge clk_i) begin
    if (accept && wr_held) begin
      held_q[wr_idx] <= data_byte_i;
    end
  end

endmodule

[rtl/core/utf8d_queue.sv]
module utf8d_queue
  import utf8d_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t run_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output run_t run_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  run_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign run_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store a run
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= run_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/core/utf8d_back.sv]
module utf8d_back
  import utf8d_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  run_t           q_run_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [CpW-1:0] code_point_o,
  output logic           replaced_o,
  output logic           run_last_o,
  output logic           text_last_o
);

  logic [1:0]     idx_q;
  logic           vld_q;
  logic [CpW-1:0] cp_q;
  logic           rep_q, rlast_q, tlast_q;
  logic           load;
  logic           last_of_run;
  logic           is_main;

  assign load        = q_valid_i && (!vld_q || out_ready_i);
  assign last_of_run = {1'b0, idx_q} == (q_run_i.count - 3'd1);
  assign is_main     = q_run_i.has_main && (idx_q == q_run_i.main_idx);
  assign q_pop_o     = load && last_of_run;

  // Step through the run, one word per cycle while the output is not stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= last_of_run ? 2'd0 : idx_q + 2'd1;
      end
      if (load) begin
        vld_q <= 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  // Hold the output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q    <= is_main ? q_run_i.main_cp : Replacement;
      rep_q   <= is_main ? q_run_i.main_rep : 1'b1;
      rlast_q <= last_of_run;
      tlast_q <= last_of_run && q_run_i.eot;
    end
  end

  assign out_valid_o  = vld_q;
  assign code_point_o = cp_q;
  assign replaced_o   = rep_q;
  assign run_last_o   = rlast_q;
  assign text_last_o  = tlast_q;

endmodule

[tb/utf8_stream_decoder_core_tb.sv]
module utf8_stream_decoder_core_tb
  import utf8d_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200_000;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           replaced;
    logic           run_last;
    logic           text_last;
  } cp_word_t;

  logic clk_i;
  logic rst_ni;

  utf8d_byte_if byte_bus ();
  utf8d_cp_if   cp_bus ();

  utf8_stream_decoder_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_bus),
    .cp_o   (cp_bus)
  );

  // Decoder shadow state
  logic [7:0] held_q [3];
  logic [1:0] held_cnt = 2'd0;
  logic [2:0] seq_len  = LenNone;

  cp_word_t    step_cps [$];
  cp_word_t    expected_cps [$];
  int unsigned err_cnt    = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_cnt  = 0;
  logic        idle_off   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Queue one code point of the current step
  function automatic void add_cp(input logic [CpW-1:0] cp, input logic rep);
    cp_word_t w;
    w.cp        = cp;
    w.replaced  = rep;
    w.run_last  = 1'b0;
    w.text_last = 1'b0;
    step_cps = {step_cps, w};
  endfunction

  // Emit one replacement per held byte, then drop the sequence
  function automatic void flush_held();
    for (int i = 0; i < int'(held_cnt); i++) add_cp(Replacement, 1'b1);
    held_cnt = 2'd0;
    seq_len  = LenNone;
  endfunction

  // Handle a byte with no sequence open
  function automatic void take_fresh(input logic [7:0] b);
    if (!b[7]) begin
      add_cp({13'd0, b}, 1'b0);
    end else if (b[7:5] == 3'b110) begin
      held_q[0] = b;
      held_cnt  = 2'd1;
      seq_len   = LenTwo;
    end else if (b[7:4] == 4'b1110) begin
      held_q[0] = b;
      held_cnt  = 2'd1;
      seq_len   = LenThree;
    end else if (b[7:3] == 5'b11110) begin
      held_q[0] = b;
      held_cnt  = 2'd1;
      seq_len   = LenFour;
    end else begin
      add_cp(Replacement, 1'b1);
    end
  endfunction

  // Work out the code points that one accepted byte causes
  function automatic void predict_byte(input logic [7:0] b, input logic eot);
    logic [CpW-1:0] value;
    logic           ok;
    cp_word_t       w;
    step_cps.delete();
    if (seq_len == LenNone || held_cnt == 2'd0) begin
      held_cnt = 2'd0;
      seq_len  = LenNone;
      take_fresh(b);
    end else if (b[7:6] == 2'b10) begin
      if (int'(held_cnt) + 1 >= int'(seq_len)) begin
        case (seq_len)
          LenTwo: begin
            value = {10'd0, held_q[0][4:0], b[5:0]};
            ok    = value >= MinTwo;
          end
          LenThree: begin
            value = {5'd0, held_q[0][3:0], held_q[1][5:0], b[5:0]};
            ok    = value >= MinThree && !(value >= SurrLo && value <= SurrHi);
          end
          default: begin
            value = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], b[5:0]};
            ok    = value >= MinFour && value <= MaxScalar;
          end
        endcase
        add_cp(ok ? value : Replacement, !ok);
        held_cnt = 2'd0;
        seq_len  = LenNone;
      end else begin
        held_q[held_cnt] = b;
        held_cnt         = held_cnt + 2'd1;
      end
    end else begin
      flush_held();
      take_fresh(b);
    end
    if (eot) flush_held();
    if (step_cps.size() > 0) begin
      w           = step_cps[step_cps.size()-1];
      w.run_last  = 1'b1;
      w.text_last = eot;
      step_cps[step_cps.size()-1] = w;
    end
    expected_cps = {expected_cps, step_cps};
  endfunction

  // Send one byte after a random gap (none while idle_off is set) and predict on acceptance
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk_i);
      byte_bus.valid = 1'b0;
    end
    @(negedge clk_i);
    byte_bus.valid       = 1'b1;
    byte_bus.data_byte   = b;
    byte_bus.end_of_text = eot;
    do @(posedge clk_i); while (!byte_bus.ready);
    predict_byte(b, eot);
    bytes_sent++;
  endtask

  // Encode a scalar in nbytes (overlong allowed) and send the first keep bytes
  task automatic send_scalar(input logic [20:0] cp, input int nbytes, input int keep,
                             input logic eot);
    logic [7:0] seq [4];
    case (nbytes)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) send_byte(seq[i], eot && i == keep - 1);
  endtask

  // Hold the sender until every expected word has come out
  task automatic wait_for_drain();
    @(negedge clk_i);
    byte_bus.valid = 1'b0;
    while (expected_cps.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
  endtask

  task automatic test_valid_sequences();
    send_scalar(21'h000080, 2, 2, 1'b0);
    send_scalar(21'h10FFFF, 4, 4, 1'b0);
    // a well-formed U+FFFD is not a replacement
    send_scalar(21'h00FFFD, 3, 3, 1'b0);
  endtask

  task automatic test_disallowed_values();
    send_scalar(21'h000000, 2, 2, 1'b0);
    send_scalar(21'h00D800, 3, 3, 1'b0);
    send_scalar(21'h110000, 4, 4, 1'b0);
  endtask

  task automatic test_stray_bytes();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Three held bytes broken by a lead that the end of text then flushes
  task automatic test_broken_sequences();
    send_scalar(21'h010000, 4, 3, 1'b0);
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic test_end_of_text();
    send_byte(8'h41, 1'b1);
  endtask

  // Mostly well-formed text with random scalars, plus cut sequences and raw bytes
  task automatic test_random_text(input int unsigned n_bytes);
    int unsigned    stop_at;
    int             act;
    int             kind;
    int             nbytes;
    logic [20:0]    cp;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 11) == 0) idle_off = ~idle_off;
      act    = $urandom_range(0, 9);
      kind   = $urandom_range(0, 7);
      nbytes = $urandom_range(1, 4);
      case (nbytes)
        1: cp = 21'($urandom_range(0, 'h7F));
        2: cp = (kind == 0) ? 21'($urandom_range(0, 'h7F)) :
                              21'($urandom_range('h80, 'h7FF));
        3: cp = (kind == 0) ? 21'($urandom_range(0, 'h7FF)) :
                (kind == 1) ? 21'($urandom_range('hD800, 'hDFFF)) :
                              21'($urandom_range('h800, 'hFFFF));
        default: cp = (kind == 0) ? 21'($urandom_range(0, 'hFFFF)) :
                      (kind == 1) ? 21'($urandom_range('h110000, 'h1FFFFF)) :
                                    21'($urandom_range('h10000, 'h10FFFF));
      endcase
      if (act <= 5) begin
        send_scalar(cp, nbytes, nbytes, $urandom_range(0, 9) == 0);
      end else if (act <= 7) begin
        nbytes = $urandom_range(2, 4);
        send_scalar(cp, nbytes, $urandom_range(1, nbytes - 1), $urandom_range(0, 2) == 0);
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // Output side: stall a random number of cycles before each word, none while idle_off is set
  initial begin
    int stall;
    cp_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      stall = idle_off ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        @(negedge clk_i);
        cp_bus.ready = 1'b0;
      end
      @(negedge clk_i);
      cp_bus.ready = 1'b1;
      do @(posedge clk_i); while (!cp_bus.valid);
    end
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin
    cp_word_t want;
    if (rst_ni && cp_bus.valid && cp_bus.ready) begin
      if (expected_cps.size() == 0) begin
        $error("code_point: no word expected, got %h", cp_bus.code_point);
        err_cnt++;
      end else begin
        want = expected_cps.pop_front();
        if (cp_bus.code_point !== want.cp) begin
          $error("code_point: expected %h, got %h", want.cp, cp_bus.code_point);
          err_cnt++;
        end
        if (cp_bus.replaced !== want.replaced) begin
          $error("replaced: expected %b, got %b", want.replaced, cp_bus.replaced);
          err_cnt++;
        end
        if (cp_bus.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, cp_bus.run_last);
          err_cnt++;
        end
        if (cp_bus.text_last !== want.text_last) begin
          $error("text_last: expected %b, got %b", want.text_last, cp_bus.text_last);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni               = 1'b0;
    byte_bus.valid       = 1'b0;
    byte_bus.data_byte   = 8'h00;
    byte_bus.end_of_text = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_ascii();
    test_valid_sequences();
    test_disallowed_values();
    test_stray_bytes();
    test_broken_sequences();
    test_end_of_text();
    wait_for_drain();

    test_random_text(52);
    wait_for_drain();
    test_random_text(52);
    wait_for_drain();

    // allow the output register to settle
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
